// ===== hw/rtl/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// shared widths, register indexes and reset values of the clamp-to-edge blur
// ----------------------------------------------------------------------------
package gbc_pkg;

   localparam int MaxWidthDefault    = 1024;
   localparam int MaxChannelsDefault = 4;
   localparam int MaxRadiusDefault   = 3;
   localparam int MaxHeight          = 1024;

   localparam int SampleWidth      = 8;
   localparam int WeightWidth      = 17;
   localparam int WeightCount      = 4;
   localparam int WeightIndexWidth = 2;
   localparam int RadiusWidth      = 2;
   localparam int DimWidth         = 11;
   localparam int RowWidth         = 10;
   localparam int ChanCountWidth   = 3;
   localparam int CsrIndexWidth    = 3;
   localparam int CsrDataWidth     = 17;
   localparam int FracBits         = 32;

   localparam logic [CsrIndexWidth-1:0] RegRadius      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegImageWidth  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegImageHeight = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegChannels    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegWeightZero  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegWeightOne   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegWeightTwo   = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegWeightThree = 3'd7;

   localparam logic [RadiusWidth-1:0]    RadiusReset   = 2'd1;
   localparam logic [DimWidth-1:0]       WidthReset    = 11'd640;
   localparam logic [DimWidth-1:0]       HeightReset   = 11'd480;
   localparam logic [ChanCountWidth-1:0] ChannelsReset = 3'd1;
   localparam logic [WeightWidth-1:0]    WeightUnity   = 17'd65536;

   localparam logic ActSample = 1'b0;
   localparam logic ActDrain  = 1'b1;

endpackage

// ===== hw/rtl/gaussian_blur_clamp_edge.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_clamp_edge
// streaming 2d gaussian blur, clamp-to-edge, separable q1.16 weights
//
//  group  dir  signals                      payload
//  req    in   req_tvalid/tready/tdata/tuser tdata: sample; tuser: action
//  rsp    out  rsp_tvalid/tready/tdata/tlast tdata: blurred; tlast: frame_end
//  csr    in   csr_wen/index/wdata          one register per write, no read
//
// an input transfer that only writes passes decide and returns to idle; one that
// yields a result also passes hold, run and flush, limited by the single read
// port of the line store feeding the tap chain one sample per cycle.
// reset is synchronous; the line store is not cleared and needs no sweep.
// req_tready stays low after a csr write until the settle counter runs down, while derived sizes settle.
// a waiting result holds only an item that yields a result, in hold.
// ----------------------------------------------------------------------------
module gaussian_blur_clamp_edge #(
   parameter int MAX_WIDTH    = gbc_pkg::MaxWidthDefault,
   parameter int MAX_CHANNELS = gbc_pkg::MaxChannelsDefault,
   parameter int MAX_RADIUS   = gbc_pkg::MaxRadiusDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gbc_pkg::SampleWidth-1:0]   req_tdata,   // [7:0] sample
   input  logic                               req_tuser,   // [0] action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gbc_pkg::SampleWidth-1:0]   rsp_tdata,   // [7:0] blurred
   output logic                               rsp_tlast,
   input  logic                               csr_wen,
   input  logic [gbc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [gbc_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import gbc_pkg::*;

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = XW + 1;
   localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNW  = $clog2(MAX_CHANNELS + 1);
   localparam int NT   = 2 * MAX_RADIUS + 1;
   localparam int KW   = $clog2(NT);
   localparam int RSW  = $clog2(2 * MAX_RADIUS + 2);
   localparam int PW   = $clog2(MaxHeight * MAX_WIDTH * MAX_CHANNELS + 1);
   localparam int RWW  = WW + RadiusWidth;
   localparam int DW   = RWW + CNW;
   localparam int HWW  = DimWidth + WW;
   localparam int TW   = HWW + CNW;
   localparam int PSW  = SampleWidth + WeightWidth + $clog2(NT);
   localparam int PRW  = PSW + WeightWidth;
   localparam int ACW  = PRW + $clog2(NT);
   localparam int MAW  = RSW + XW + CHW;

   typedef enum logic [4:0] {
      IDLE   = 5'b00001,
      DECIDE = 5'b00010,
      HOLD   = 5'b00100,
      RUN    = 5'b01000,
      FLUSH  = 5'b10000
   } state_type;

   // configuration
   logic [RadiusWidth-1:0]    radius_ff;
   logic [DimWidth-1:0]       width_ff, height_ff;
   logic [ChanCountWidth-1:0] chans_ff;
   logic [WeightWidth-1:0]    wt_ff [0:WeightCount-1];
   logic [1:0]                settle_ff;

   logic [RadiusWidth-1:0] r_eff;
   logic [WW-1:0]          w_eff;
   logic [DimWidth-1:0]    h_eff;
   logic [CNW-1:0]         c_eff;

   logic [RWW-1:0] rw_ff, rw_in;
   logic [DW-1:0]  delay_ff, delay_in;
   logic [HWW-1:0] hw_ff, hw_in;
   logic [PW-1:0]  total_ff, total_in;

   // control
   state_type             state_ff, state_in;
   logic                  act_ff;
   logic [SampleWidth-1:0] smp_ff;
   logic [RowWidth-1:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [XW-1:0]         in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [CHW-1:0]        in_ch_ff, in_ch_in, out_ch_ff, out_ch_in;
   logic [PW-1:0]         n_ff, n_in, out_pos_ff, out_pos_in;
   logic                  done_ff, done_in, final_ff, final_in;
   logic [KW-1:0]         ky_ff, ky_in, kx_ff, kx_in;

   logic                  done0, done1, do_write, emit;
   logic                  wr_en;
   logic [MAW-1:0]        wr_addr, rd_addr;
   logic                  iss;

   // tap addressing
   logic [DimWidth-1:0]   ny_t, ny;
   logic [WW-1:0]         nx_t, nx;
   logic [KW-1:0]         dxa, dya;
   logic [KW-1:0]         ky_last;

   // pipeline tags
   logic                  b_vld_ff, b_mask_ff, b_end_ff, b_last_ff;
   logic [WeightIndexWidth-1:0] b_wsel_ff, c_wsel_ff;
   logic                  c_end_ff, c_last_ff;
   logic                  d_vld_ff, d_final_ff;
   logic [PRW-1:0]        prod_ff, prod_in;
   logic [ACW-1:0]        acc_ff, acc_in, acc_sum;

   logic [SampleWidth-1:0] rd_data;
   logic [SampleWidth-1:0] x_b;
   logic [PSW-1:0]         psum [0:NT-1];

   logic                   rsp_tvalid_ff, rsp_tvalid_in, rsp_tlast_ff;
   logic [SampleWidth-1:0] rsp_tdata_ff, blurred;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
         chans_ff  <= ChannelsReset;
         wt_ff[0]  <= WeightUnity;
         wt_ff[1]  <= '0;
         wt_ff[2]  <= '0;
         wt_ff[3]  <= '0;
         settle_ff <= 2'd3;
      end else begin
         if (csr_wen) begin
            settle_ff <= 2'd3;
            case (csr_index)
               RegRadius:      radius_ff <= csr_wdata[RadiusWidth-1:0];
               RegImageWidth:  width_ff  <= csr_wdata[DimWidth-1:0];
               RegImageHeight: height_ff <= csr_wdata[DimWidth-1:0];
               RegChannels:    chans_ff  <= csr_wdata[ChanCountWidth-1:0];
               RegWeightZero:  wt_ff[0]  <= csr_wdata;
               RegWeightOne:   wt_ff[1]  <= csr_wdata;
               RegWeightTwo:   wt_ff[2]  <= csr_wdata;
               RegWeightThree: wt_ff[3]  <= csr_wdata;
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_comb begin
      r_eff = (radius_ff > MAX_RADIUS) ? RadiusWidth'(MAX_RADIUS) : radius_ff;
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (width_ff > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = DimWidth'(1);
      end else if (height_ff > MaxHeight) begin
         h_eff = DimWidth'(MaxHeight);
      end else begin
         h_eff = height_ff;
      end
      if (chans_ff == '0) begin
         c_eff = CNW'(1);
      end else if (chans_ff > MAX_CHANNELS) begin
         c_eff = CNW'(MAX_CHANNELS);
      end else begin
         c_eff = CNW'(chans_ff);
      end
      rw_in    = RWW'(RWW'(r_eff) * RWW'(w_eff) + RWW'(r_eff));
      delay_in = DW'(DW'(rw_ff) * DW'(c_eff));
      hw_in    = HWW'(HWW'(h_eff) * HWW'(w_eff));
      total_in = PW'(TW'(hw_ff) * TW'(c_eff));
   end

   always_ff @(posedge clock) begin
      rw_ff    <= rw_in;
      delay_ff <= delay_in;
      hw_ff    <= hw_in;
      total_ff <= total_in;
   end

   // sequencer
   assign req_tready = (state_ff == IDLE) && (settle_ff == 2'd0);
   assign iss        = (state_ff == RUN);
   assign ky_last    = KW'(MAX_RADIUS) + KW'(r_eff);

   always_comb begin
      state_in   = state_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_ch_in   = in_ch_ff;
      n_in       = n_ff;
      done_in    = done_ff;
      out_pos_in = out_pos_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_ch_in  = out_ch_ff;
      final_in   = final_ff;
      ky_in      = ky_ff;
      kx_in      = kx_ff;
      wr_en      = 1'b0;
      done0      = done_ff || (h_eff <= DimWidth'(in_row_ff)) ||
                   (w_eff <= WW'(in_col_ff)) || (c_eff <= CNW'(in_ch_ff));
      do_write   = (act_ff == ActSample) && !done0;
      done1      = 1'b0;
      emit       = 1'b0;

      case (state_ff)
         IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            done_in = done0;
            if (do_write) begin
               wr_en = 1'b1;
               n_in  = n_ff + 1'b1;
               if (CNW'(in_ch_ff) + 1'b1 < c_eff) begin
                  in_ch_in = in_ch_ff + 1'b1;
               end else begin
                  in_ch_in = '0;
                  if (WW'(in_col_ff) + 1'b1 < w_eff) begin
                     in_col_in = in_col_ff + 1'b1;
                  end else begin
                     in_col_in = '0;
                     if (DimWidth'(in_row_ff) + 1'b1 < h_eff) begin
                        in_row_in = in_row_ff + 1'b1;
                     end else begin
                        in_row_in = '0;
                        done1     = 1'b1;
                     end
                  end
               end
               done_in = done1;
               emit    = done1 || ((PW+1)'(n_ff) >=
                         (PW+1)'(out_pos_ff) + (PW+1)'(delay_ff));
            end else begin
               emit = done0;
            end
            if (out_pos_ff >= total_ff) begin
               in_row_in  = '0;
               in_col_in  = '0;
               in_ch_in   = '0;
               n_in       = '0;
               done_in    = 1'b0;
               out_pos_in = '0;
               out_row_in = '0;
               out_col_in = '0;
               out_ch_in  = '0;
               state_in   = IDLE;
            end else if (!emit) begin
               state_in = IDLE;
            end else begin
               final_in = ((PW+1)'(out_pos_ff) + 1'b1 == (PW+1)'(total_ff));
               state_in = HOLD;
            end
         end
         HOLD: begin
            if (!rsp_tvalid_ff) begin
               ky_in    = KW'(MAX_RADIUS) - KW'(r_eff);
               kx_in    = '0;
               state_in = RUN;
            end
         end
         RUN: begin
            if (kx_ff == KW'(NT - 1)) begin
               kx_in = '0;
               if (ky_ff == ky_last) begin
                  state_in = FLUSH;
               end else begin
                  ky_in = ky_ff + 1'b1;
               end
            end else begin
               kx_in = kx_ff + 1'b1;
            end
         end
         FLUSH: begin
            if (d_final_ff) begin
               state_in = IDLE;
               if (final_ff) begin
                  in_row_in  = '0;
                  in_col_in  = '0;
                  in_ch_in   = '0;
                  n_in       = '0;
                  done_in    = 1'b0;
                  out_pos_in = '0;
                  out_row_in = '0;
                  out_col_in = '0;
                  out_ch_in  = '0;
               end else begin
                  out_pos_in = out_pos_ff + 1'b1;
                  if (CNW'(out_ch_ff) + 1'b1 < c_eff) begin
                     out_ch_in = out_ch_ff + 1'b1;
                  end else begin
                     out_ch_in = '0;
                     if (WW'(out_col_ff) + 1'b1 < w_eff) begin
                        out_col_in = out_col_ff + 1'b1;
                     end else begin
                        out_col_in = '0;
                        out_row_in = out_row_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_ch_ff   <= '0;
         n_ff       <= '0;
         done_ff    <= 1'b0;
         out_pos_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         out_ch_ff  <= '0;
         final_ff   <= 1'b0;
         ky_ff      <= '0;
         kx_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_ch_ff   <= in_ch_in;
         n_ff       <= n_in;
         done_ff    <= done_in;
         out_pos_ff <= out_pos_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         out_ch_ff  <= out_ch_in;
         final_ff   <= final_in;
         ky_ff      <= ky_in;
         kx_ff      <= kx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tuser;
         smp_ff <= req_tdata;
      end
   end

   // clamped neighbour address
   always_comb begin
      ny_t = DimWidth'(out_row_ff) + DimWidth'(ky_ff);
      if (ny_t < DimWidth'(MAX_RADIUS)) begin
         ny = '0;
      end else if (ny_t - DimWidth'(MAX_RADIUS) >= h_eff) begin
         ny = h_eff - 1'b1;
      end else begin
         ny = ny_t - DimWidth'(MAX_RADIUS);
      end
      nx_t = WW'(out_col_ff) + WW'(kx_ff);
      if (nx_t < WW'(MAX_RADIUS)) begin
         nx = '0;
      end else if (nx_t - WW'(MAX_RADIUS) >= w_eff) begin
         nx = w_eff - 1'b1;
      end else begin
         nx = nx_t - WW'(MAX_RADIUS);
      end
      dxa = (kx_ff >= KW'(MAX_RADIUS)) ? kx_ff - KW'(MAX_RADIUS) : KW'(MAX_RADIUS) - kx_ff;
      dya = (ky_ff >= KW'(MAX_RADIUS)) ? ky_ff - KW'(MAX_RADIUS) : KW'(MAX_RADIUS) - ky_ff;
   end

   assign wr_addr = {in_row_ff[RSW-1:0], in_col_ff, in_ch_ff};
   assign rd_addr = {ny[RSW-1:0], nx[XW-1:0], out_ch_ff};

   gbc_line_store #(
      .ADDR_WIDTH(MAW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (smp_ff),
      .rd_en      (iss),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // tap tags follow the read data down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         c_end_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         d_final_ff <= 1'b0;
      end else begin
         b_vld_ff   <= iss;
         c_end_ff   <= b_vld_ff && b_end_ff;
         d_vld_ff   <= c_end_ff;
         d_final_ff <= c_end_ff && c_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_mask_ff <= (dxa <= KW'(r_eff));
      b_end_ff  <= (kx_ff == KW'(NT - 1));
      b_last_ff <= (ky_ff == ky_last);
      b_wsel_ff <= WeightIndexWidth'(dya);
      c_last_ff <= b_last_ff;
      c_wsel_ff <= b_wsel_ff;
      prod_ff   <= prod_in;
   end

   assign x_b = (b_vld_ff && b_mask_ff) ? rd_data : '0;

   for (genvar k = 0; k < NT; k++) begin : g_cell
      localparam int Off = (k >= MAX_RADIUS) ? k - MAX_RADIUS : MAX_RADIUS - k;
      if (k == 0) begin : g_head
         gbc_cell #(
            .PSUM_WIDTH(PSW)
         ) u_cell (
            .clock     (clock),
            .sample_in (x_b),
            .weight    (wt_ff[Off]),
            .psum_in   ({PSW{1'b0}}),
            .psum_ff   (psum[k])
         );
      end else begin : g_body
         gbc_cell #(
            .PSUM_WIDTH(PSW)
         ) u_cell (
            .clock     (clock),
            .sample_in (x_b),
            .weight    (wt_ff[Off]),
            .psum_in   (psum[k-1]),
            .psum_ff   (psum[k])
         );
      end
   end

   // vertical weighting and accumulation
   always_comb begin
      prod_in = PRW'(psum[NT-1]) * PRW'(wt_ff[c_wsel_ff]);
      acc_sum = acc_ff + ACW'(prod_ff);
      acc_in  = acc_ff;
      if (d_vld_ff) begin
         acc_in = d_final_ff ? '0 : acc_sum;
      end
      if (|acc_sum[ACW-1:FracBits+SampleWidth]) begin
         blurred = '1;
      end else begin
         blurred = acc_sum[FracBits+SampleWidth-1:FracBits];
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (d_final_ff) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_final_ff) begin
         rsp_tdata_ff <= blurred;
         rsp_tlast_ff <= final_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_out_free : assert property (@(posedge clock) disable iff (reset)
      d_final_ff |-> !rsp_tvalid_ff)
      else $error("result ready while output register full");

   a_final_in_flush : assert property (@(posedge clock) disable iff (reset)
      d_final_ff |-> (state_ff == FLUSH))
      else $error("result finished outside flush");

   a_row_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> (ky_ff <= ky_last))
      else $error("tap row beyond radius");

endmodule

// ===== hw/rtl/gbc_cell.sv =====
// ----------------------------------------------------------------------------
// gbc_cell
// one tap of the horizontal chain: weighted sample added to the partial sum
// ----------------------------------------------------------------------------
module gbc_cell #(
   parameter int PSUM_WIDTH = 28
) (
   input  logic                              clock,
   input  logic [gbc_pkg::SampleWidth-1:0]  sample_in,
   input  logic [gbc_pkg::WeightWidth-1:0]  weight,
   input  logic [PSUM_WIDTH-1:0]             psum_in,
   output logic [PSUM_WIDTH-1:0]             psum_ff
);
   import gbc_pkg::*;

   localparam int ProdWidth = SampleWidth + WeightWidth;

   logic [ProdWidth-1:0]  prod;
   logic [PSUM_WIDTH-1:0] psum_in_next;

   assign prod         = ProdWidth'(sample_in) * ProdWidth'(weight);
   assign psum_in_next = psum_in + PSUM_WIDTH'(prod);

   always_ff @(posedge clock) begin
      psum_ff <= psum_in_next;
   end

endmodule

// ===== hw/rtl/gbc_line_store.sv =====
// ----------------------------------------------------------------------------
// gbc_line_store
// ring of image rows, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gbc_line_store #(
   parameter int ADDR_WIDTH = 15
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [ADDR_WIDTH-1:0]            wr_addr,
   input  logic [gbc_pkg::SampleWidth-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [ADDR_WIDTH-1:0]            rd_addr,
   output logic [gbc_pkg::SampleWidth-1:0] rd_data_ff
);
   import gbc_pkg::*;

   logic [SampleWidth-1:0] mem [0:(2**ADDR_WIDTH)-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== dv/gaussian_blur_clamp_edge_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_clamp_edge_tb
// streams whole frames of interleaved samples through the clamp-to-edge blur
// and checks every blurred sample and frame end against a cycle-free model of
// the filter; register settings change between frames, both stream sides idle
// and stall at random, and out-of-range settings and stray drain ticks appear
// ----------------------------------------------------------------------------
module gaussian_blur_clamp_edge_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gbc_pkg::*;

   localparam int RingSize = (2 * MaxRadiusDefault + 1) * MaxWidthDefault * MaxChannelsDefault;
   localparam int SettleCycles = 80;

   typedef struct packed {
      logic                   action;
      logic [SampleWidth-1:0] sample;
   } pixel_in_t;

   typedef struct packed {
      logic [SampleWidth-1:0] blurred;
      logic                   frame_end;
   } pixel_out_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [SampleWidth-1:0] req_tdata = '0;   // [7:0] sample
   logic req_tuser = 1'b0;                   // [0] action
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SampleWidth-1:0] rsp_tdata;        // [7:0] blurred
   logic rsp_tlast;
   logic csr_wen = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   gaussian_blur_clamp_edge u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // filter mirror
   logic [RadiusWidth-1:0]    cfg_radius   = RadiusReset;
   logic [DimWidth-1:0]       cfg_width    = WidthReset;
   logic [DimWidth-1:0]       cfg_height   = HeightReset;
   logic [ChanCountWidth-1:0] cfg_channels = ChannelsReset;
   logic [WeightWidth-1:0]    cfg_weight [WeightCount] = '{WeightUnity, '0, '0, '0};
   logic [SampleWidth-1:0]    line_mem [RingSize];
   int unsigned in_row, in_col, in_chan, out_pos;
   bit in_done;

   pixel_in_t  stim_queue [$];
   pixel_out_t blur_expected [$];
   pixel_in_t  next_pixel;
   pixel_out_t got_pixel;
   bit req_taken;
   int send_gap_pct, stall_pct, failures, stim_count;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
   endfunction

   function automatic void restart_counters();
      in_row = 0; in_col = 0; in_chan = 0; out_pos = 0; in_done = 0;
   endfunction

   function automatic bit blur_predict(input pixel_in_t px, output pixel_out_t res);
      int unsigned r, w, h, c, o, oc, pix;
      longint unsigned total, delay, n, acc, wy, wx, idx;
      int ox, oy, ny, nx;
      bit emit;
      r = cfg_radius;
      w = clamp_dim(cfg_width, MaxWidthDefault);
      h = clamp_dim(cfg_height, MaxHeight);
      c = clamp_dim(cfg_channels, MaxChannelsDefault);
      total = longint'(h) * w * c;
      delay = (longint'(r) * w + r) * c;
      emit = 0;
      res = '0;
      if (!in_done && (in_row >= h || in_col >= w || in_chan >= c)) in_done = 1;
      if (px.action == ActSample && !in_done) begin
         n = (longint'(in_row) * w + in_col) * c + in_chan;
         line_mem[n % RingSize] = px.sample;
         if (in_chan + 1 < c) begin
            in_chan++;
         end else begin
            in_chan = 0;
            if (in_col + 1 < w) begin
               in_col++;
            end else begin
               in_col = 0;
               if (in_row + 1 < h) begin
                  in_row++;
               end else begin
                  in_row = 0;
                  in_done = 1;
               end
            end
         end
         emit = in_done || n >= longint'(out_pos) + delay;
      end else if (in_done) begin
         emit = 1;
      end
      if (longint'(out_pos) >= total) begin
         restart_counters();
         return 0;
      end
      if (!emit) return 0;
      o = out_pos;
      oc = o % c;
      pix = o / c;
      ox = pix % w;
      oy = pix / w;
      acc = 0;
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
         ny = oy + dy;
         wy = cfg_weight[dy < 0 ? -dy : dy];
         if (ny < 0) ny = 0;
         if (ny > int'(h) - 1) ny = h - 1;
         for (int dx = -int'(r); dx <= int'(r); dx++) begin
            nx = ox + dx;
            wx = cfg_weight[dx < 0 ? -dx : dx];
            if (nx < 0) nx = 0;
            if (nx > int'(w) - 1) nx = w - 1;
            idx = ((longint'(ny) * w + nx) * c + oc) % RingSize;
            acc += wy * wx * line_mem[idx];
         end
      end
      acc = acc >> FracBits;
      res.blurred = (acc > 255) ? 8'hFF : acc[7:0];
      if (longint'(o) + 1 == total) begin
         res.frame_end = 1'b1;
         restart_counters();
      end else begin
         out_pos = o + 1;
      end
      return 1;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      req_taken = 0;
      if (!reset && req_tvalid && req_tready) begin
         req_taken = 1;
         if (blur_predict(pixel_in_t'{req_tuser, req_tdata}, got_pixel))
            blur_expected.push_back(got_pixel);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (stim_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            next_pixel = stim_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_pixel.action;
            req_tdata  <= next_pixel.sample;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blur_expected.size() == 0) begin
            $error("unexpected transfer: blurred %0d frame_end %0d", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            got_pixel = blur_expected.pop_front();
            if (rsp_tdata !== got_pixel.blurred) begin
               $error("blurred: expected %0d, got %0d", got_pixel.blurred, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== got_pixel.frame_end) begin
               $error("frame_end: expected %0d, got %0d", got_pixel.frame_end, rsp_tlast);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic wait_drained();
      while (stim_queue.size() != 0 || req_tvalid || blur_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         RegRadius:      cfg_radius   = val[RadiusWidth-1:0];
         RegImageWidth:  cfg_width    = val[DimWidth-1:0];
         RegImageHeight: cfg_height   = val[DimWidth-1:0];
         RegChannels:    cfg_channels = val[ChanCountWidth-1:0];
         RegWeightZero:  cfg_weight[0] = val;
         RegWeightOne:   cfg_weight[1] = val;
         RegWeightTwo:   cfg_weight[2] = val;
         RegWeightThree: cfg_weight[3] = val;
         default: ;
      endcase
   endtask

   task automatic set_filter(input int r, input int w, input int h, input int c,
                             input int w0, input int w1, input int w2, input int w3);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      csr_write(RegRadius, CsrDataWidth'(r));
      csr_write(RegImageWidth, CsrDataWidth'(w));
      csr_write(RegImageHeight, CsrDataWidth'(h));
      csr_write(RegChannels, CsrDataWidth'(c));
      csr_write(RegWeightZero, CsrDataWidth'(w0));
      csr_write(RegWeightOne, CsrDataWidth'(w1));
      csr_write(RegWeightTwo, CsrDataWidth'(w2));
      csr_write(RegWeightThree, CsrDataWidth'(w3));
   endtask

   // one whole frame plus the drain ticks that flush it
   task automatic push_frame(input int fixed_val, input int pause_at, input bit noisy);
      int unsigned r, w, h, c;
      longint unsigned total, delay, emitted;
      r = cfg_radius;
      w = clamp_dim(cfg_width, MaxWidthDefault);
      h = clamp_dim(cfg_height, MaxHeight);
      c = clamp_dim(cfg_channels, MaxChannelsDefault);
      total = longint'(h) * w * c;
      delay = (longint'(r) * w + r) * c;
      emitted = (total > delay) ? total - delay : 1;
      for (longint unsigned i = 0; i < total; i++) begin
         if (i == pause_at) wait_drained();
         if (noisy && $urandom_range(15) == 0)
            stim_queue.push_back('{ActDrain, 8'($urandom_range(255))});
         stim_queue.push_back('{ActSample,
                                8'(fixed_val < 0 ? $urandom_range(255) : fixed_val)});
         stim_count++;
      end
      for (longint unsigned i = 0; i < total - emitted; i++) begin
         // a sample after the last one of the frame acts as a drain tick
         if ($urandom_range(3) == 0)
            stim_queue.push_back('{ActSample, 8'($urandom_range(255))});
         else
            stim_queue.push_back('{ActDrain, 8'($urandom_range(255))});
         stim_count++;
      end
   endtask

   function automatic int rand_weight();
      case ($urandom_range(7))
         0: return 0;
         1: return 65536;
         2: return $urandom_range(131071);
         default: return $urandom_range(40000);
      endcase
   endfunction

   task automatic set_idling(input int sel);
      case (sel % 4)
         0: begin send_gap_pct = 0;  stall_pct = 0;  end
         1: begin send_gap_pct = 62; stall_pct = 0;  end
         2: begin send_gap_pct = 0;  stall_pct = 62; end
         default: begin send_gap_pct = 38; stall_pct = 38; end
      endcase
   endtask

   initial begin
      int frame_no;
      restart_counters();
      stim_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single pixel, largest radius, both sample extremes
      set_filter(3, 1, 1, 1, 65536, 0, 0, 0);
      push_frame(255, -1, 0);
      push_frame(0, -1, 0);
      // saturating weights, four channels, sender holds off mid-frame
      set_idling(3);
      set_filter(3, 3, 2, 4, 131071, 131071, 131071, 131071);
      push_frame(-1, 10, 1);
      set_idling(0);
      set_filter(0, 2, 1, 1, 0, 0, 0, 0);
      push_frame(-1, -1, 1);
      // out-of-range sizes, clamped
      set_idling(2);
      set_filter(0, 2047, 0, 0, 65536, 1, 2, 3);
      push_frame(-1, -1, 0);
      set_idling(1);
      set_filter(2, 0, 2047, 7, 32768, 16384, 8192, 4096);
      set_filter(1, 0, 3, 7, 40000, 0, 0, 0);
      push_frame(-1, -1, 0);

      frame_no = 0;
      while (stim_count < 1350) begin
         set_idling(frame_no / 2);
         set_filter($urandom_range(3), $urandom_range(8, 1), $urandom_range(6, 1),
                    $urandom_range(4, 1), rand_weight(), rand_weight(),
                    rand_weight(), rand_weight());
         repeat ($urandom_range(2, 1)) push_frame(-1, -1, 1);
         frame_no++;
      end

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (blur_expected.size() != 0) failures++;
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
